/* design/rbd_pkg.sv */
// Package for the ring buffer deque: command and status codes, and the beat
// structs for the command, result and internal result-info paths.
// No dependencies.
package rbd_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_GET        = 3'd3,
    CMD_CLEAR      = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] item_value;
    logic [3:0]  offset;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [1:0]  status;
    logic [4:0]  occupancy;
  } out_beat_t;

  // What the controller decides for one command, before the read data returns.
  typedef struct packed {
    logic        rd_used;
    status_t     status;
    logic [4:0]  occupancy;
  } res_info_t;

endpackage

/* design/ring_buffer_deque_top.sv */
// Ring buffer deque, top level: command register, controller and result register.
// A command waits in the command register until the result register is free.
// Throughput: one command per cycle while out_ready is high; each touches at most
// one entry of the store. Reset clears the head pointer, the entry count and
// both stage valids; the entry store is not cleared and needs no clearing pass.
// Depends on rbd_pkg and rbd_ctrl.
module ring_buffer_deque_top
  import rbd_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  logic        stage_valid_r;
  in_beat_t    stage_beat_r;
  logic        out_valid_r;
  res_info_t   out_info_r;
  res_info_t   info_nxt;
  logic [31:0] rd_value;
  logic        out_free, proc_en;

  // The result register frees up when empty or when its beat leaves.
  assign out_free = !out_valid_r || out_ready;
  assign proc_en  = stage_valid_r && out_free;
  assign in_ready = !stage_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (in_ready) begin
        stage_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= stage_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_beat_r <= in_data;
    end
    if (proc_en) begin
      out_info_r <= info_nxt;
    end
  end

  rbd_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .proc_en  (proc_en),
    .cmd_beat (stage_beat_r),
    .info_nxt (info_nxt),
    .rd_value (rd_value)
  );

  // The store's read register holds while the result waits, since reads only
  // fire with proc_en.
  assign out_valid = out_valid_r;
  assign out_data  = '{
    read_value: (out_info_r.rd_used ? rd_value : 32'd0),
    status:     out_info_r.status,
    occupancy:  out_info_r.occupancy
  };

endmodule

/* design/rbd_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module rbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/rbd_ctrl.sv */
// Deque controller: head pointer, entry count and command decode, driving the
// entry store. Depends on rbd_pkg and rbd_ram.
module rbd_ctrl
  import rbd_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        proc_en,
  input  in_beat_t    cmd_beat,
  output res_info_t   info_nxt,
  output logic [31:0] rd_value
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [PTR_W-1:0]      head_r, head_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  we, re;
  logic [PTR_W-1:0]      waddr, raddr;
  logic [DATA_WIDTH-1:0] wdata, rdata;
  logic                  full, empty, off_out;
  logic [PTR_W-1:0]      off_ptr, tail_ptr;
  logic [PTR_W+3:0]      off_ext;
  logic [CNT_W+3:0]      off_cmp, cnt_cmp;
  logic [CNT_W+4:0]      occ_ext;
  logic [DATA_WIDTH+31:0] wr_ext;
  logic [DATA_WIDTH+31:0] rd_ext;
  logic                  rd_used;
  status_t               status;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign off_ext  = {{PTR_W{1'b0}}, cmd_beat.offset};
  assign off_ptr  = off_ext[PTR_W-1:0];
  assign tail_ptr = head_r + count_r[PTR_W-1:0];
  assign off_cmp  = {{CNT_W{1'b0}}, cmd_beat.offset};
  assign cnt_cmp  = {4'b0, count_r};
  assign off_out  = (off_cmp >= cnt_cmp);
  assign wr_ext   = {{DATA_WIDTH{1'b0}}, cmd_beat.item_value};
  assign wdata    = wr_ext[DATA_WIDTH-1:0];

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    we        = 1'b0;
    waddr     = tail_ptr;
    raddr     = head_r;
    rd_used   = 1'b0;
    status    = ST_OK;
    case (cmd_t'(cmd_beat.command))
      CMD_PUSH_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          we        = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          we        = 1'b1;
          head_nxt  = head_r - 1'b1;
          waddr     = head_r - 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          rd_used   = 1'b1;
          head_nxt  = head_r + 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      CMD_GET: begin
        raddr = head_r + off_ptr;
        if (off_out) begin
          status = ST_RANGE;
        end else begin
          rd_used = 1'b1;
        end
      end
      CMD_CLEAR: begin
        head_nxt  = '0;
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  assign re = proc_en && rd_used;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (proc_en) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  rbd_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (proc_en && we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign occ_ext  = {5'b0, count_nxt};
  assign info_nxt = '{rd_used: rd_used, status: status, occupancy: occ_ext[4:0]};
  assign rd_ext   = {32'b0, rdata};
  assign rd_value = rd_ext[31:0];

endmodule
